// ===== hw/rtl/lnds_pkg.sv =====
// Shared package for the longest non-decreasing subsequence block.
// Holds the field widths, parameter defaults and the controller/datapath interface structs.
// Depends on nothing.
package lnds_pkg;

  // Parameter defaults.
  localparam int unsigned MAX_LEN_DEF    = 256;
  localparam int unsigned VALUE_BITS_DEF = 32;

  // Fixed port field widths.
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned LEN_W   = 9;
  localparam int unsigned IDX_W   = 8;

  // The element index saturates at this value.
  localparam logic [IDX_W-1:0] IDX_MAX = {IDX_W{1'b1}};

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the incoming transaction, clear state on start
    logic init;      // compute the first probe from the search bounds
    logic step;      // one search step on the tail read back from memory
    logic update;    // write the tail, update the counters and the results
    logic out_load;  // move the results into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic init_more;  // the initial search range is not empty
    logic step_more;  // the range is still not empty after this step
    logic out_free;   // the output register can take a new result
  } status_t;

endpackage

// ===== hw/rtl/lnds_ctrl.sv =====
// Controller for the longest non-decreasing subsequence block.
// Sequences accept, binary search, update and output hand-off.
// Depends on lnds_pkg.
module lnds_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lnds_pkg::status_t status,
  output lnds_pkg::cmd_t    cmd
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_START  = 5'b00010,
    ST_SEARCH = 5'b00100,
    ST_UPDATE = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  // Input is refused while reset is held so that no transaction is dropped.
  assign in_ready = (state == ST_IDLE) && !rst;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load   = 1'b1;
          state_next = ST_START;
        end
      end
      ST_START: begin
        cmd.init   = 1'b1;
        state_next = status.init_more ? ST_SEARCH : ST_UPDATE;
      end
      ST_SEARCH: begin
        cmd.step = 1'b1;
        if (!status.step_more) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hw/rtl/lnds_datapath.sv =====
// Datapath for the longest non-decreasing subsequence block.
// Holds the tail memory, the search bounds, the sequence counters and the output register.
// Depends on lnds_pkg.
module lnds_datapath #(
  parameter int unsigned MAX_LEN    = lnds_pkg::MAX_LEN_DEF,
  parameter int unsigned VALUE_BITS = lnds_pkg::VALUE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  lnds_pkg::cmd_t                     cmd,
  output lnds_pkg::status_t                  status,
  input  logic signed [lnds_pkg::VALUE_W-1:0] value,
  input  logic                               start_req,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [lnds_pkg::LEN_W-1:0]         end_length,
  output logic [lnds_pkg::LEN_W-1:0]         best_length,
  output logic [lnds_pkg::IDX_W-1:0]         best_index,
  output logic                               overflow
);

  localparam int unsigned AW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_LEN + 1);
  localparam int unsigned LW    = lnds_pkg::LEN_W;
  localparam int unsigned IW    = lnds_pkg::IDX_W;
  localparam int unsigned VW    = VALUE_BITS;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LEN);

  // Tail memory, one write and one registered read port.
  logic [VW-1:0] tails [MAX_LEN];
  logic [VW-1:0] rd_data;
  logic [AW-1:0] rd_addr;

  // Search registers.
  logic [VW-1:0]    key;
  logic [CNT_W-1:0] lo;
  logic [CNT_W-1:0] hi;

  // Sequence state.
  logic [CNT_W-1:0] tail_count;
  logic [IW-1:0]    elem_idx;
  logic [CNT_W-1:0] best_len;
  logic [IW-1:0]    best_pos;

  // Results waiting for the output register.
  logic [CNT_W-1:0] res_end;
  logic [CNT_W-1:0] res_best;
  logic [IW-1:0]    res_pos;
  logic             res_ovf;

  // Key forming: take the low VALUE_BITS bits and flip the sign so that
  // unsigned order matches signed order.
  logic [VW+lnds_pkg::VALUE_W-1:0] value_ext;
  logic [VW-1:0]                   key_in;

  assign value_ext = {{VW{1'b0}}, value};
  assign key_in    = value_ext[VW-1:0] ^ {1'b1, {(VW-1){1'b0}}};

  // One search step on the tail read back at the current probe.
  logic             tail_gt;
  logic [CNT_W-1:0] lo_step;
  logic [CNT_W-1:0] hi_step;
  logic [CNT_W-1:0] lo_sel;
  logic [CNT_W-1:0] hi_sel;
  logic [CNT_W-1:0] mid_calc;
  logic [CNT_W-1:0] mid;

  assign tail_gt  = (rd_data > key);
  assign lo_step  = tail_gt ? lo : mid + CNT_W'(1);
  assign hi_step  = tail_gt ? mid : hi;
  assign lo_sel   = cmd.step ? lo_step : lo;
  assign hi_sel   = cmd.step ? hi_step : hi;
  assign mid_calc = lo_sel + ((hi_sel - lo_sel) >> 1);
  assign rd_addr  = mid_calc[AW-1:0];

  assign status.init_more = (lo < hi);
  assign status.step_more = (lo_step < hi_step);
  assign status.out_free  = !out_valid || out_ready;

  // Update: the slot is lo. A full table leaves lo at MAX_LEN.
  logic             full_hit;
  logic [CNT_W-1:0] end_len;

  assign full_hit = (lo == MAX_CNT);
  assign end_len  = full_hit ? MAX_CNT : lo + CNT_W'(1);

  always_ff @(posedge clk) begin
    rd_data <= tails[rd_addr];
    if (cmd.update && !full_hit) begin
      tails[lo[AW-1:0]] <= key;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key <= key_in;
      lo  <= '0;
      hi  <= start_req ? '0 : tail_count;
    end
    if (cmd.init || cmd.step) begin
      mid <= mid_calc;
    end
    if (cmd.step) begin
      lo <= lo_step;
      hi <= hi_step;
    end
    if (cmd.update) begin
      res_end <= end_len;
      res_ovf <= full_hit;
      if (end_len > best_len) begin
        res_best <= end_len;
        res_pos  <= elem_idx;
      end else begin
        res_best <= best_len;
        res_pos  <= best_pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tail_count <= '0;
      elem_idx   <= '0;
      best_len   <= '0;
      best_pos   <= '0;
    end else if (cmd.load && start_req) begin
      tail_count <= '0;
      elem_idx   <= '0;
      best_len   <= '0;
      best_pos   <= '0;
    end else if (cmd.update) begin
      if (lo == tail_count && !full_hit) begin
        tail_count <= tail_count + CNT_W'(1);
      end
      if (end_len > best_len) begin
        best_len <= end_len;
        best_pos <= elem_idx;
      end
      if (elem_idx != lnds_pkg::IDX_MAX) begin
        elem_idx <= elem_idx + IW'(1);
      end
    end
  end

  // Output register; lengths are trimmed or padded to the port width.
  logic [LW+CNT_W-1:0] end_ext;
  logic [LW+CNT_W-1:0] best_ext;

  assign end_ext  = {{LW{1'b0}}, res_end};
  assign best_ext = {{LW{1'b0}}, res_best};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      end_length  <= end_ext[LW-1:0];
      best_length <= best_ext[LW-1:0];
      best_index  <= res_pos;
      overflow    <= res_ovf;
    end
  end

endmodule

// ===== hw/rtl/longest_nondecreasing_subseq.sv =====
// Streaming longest non-decreasing subsequence, top level.
// Joins the controller (lnds_ctrl) and the datapath (lnds_datapath); uses lnds_pkg.
//
// The block takes one signed value per input transaction and returns exactly one
// result transaction for it: the length of the longest non-decreasing subsequence
// that ends at this element, the best such length so far in the sequence, the
// earliest element index that reached it, and an overflow flag. A transaction with
// start_req high opens a new sequence and becomes element 0; after reset the block
// already behaves as if a sequence had been opened. Internally the block keeps a
// sorted table of the smallest tail value for each length and binary-searches it
// for the first tail strictly greater than the value (an upper bound), one probe per
// cycle through the single read port of the tail memory. An item therefore goes
// through accept, setup, the binary-search probes, update and hand-off, in that
// order, with no probe when the search range is empty, as for the first element
// of a sequence, and hand-off waits for a free output register. The next
// item is accepted once the previous result sits in the output register, so a
// result waiting for the consumer overlaps the search of the following item. When
// the table holds MAX_LEN tails and the value is not below any of them, the length
// saturates at MAX_LEN and overflow is set. Element indexes saturate at 255. Only
// the low VALUE_BITS bits of value take part, read as two's complement.
module longest_nondecreasing_subseq #(
  parameter int unsigned MAX_LEN    = lnds_pkg::MAX_LEN_DEF,
  parameter int unsigned VALUE_BITS = lnds_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [lnds_pkg::VALUE_W-1:0] value,
  input  logic                                start_req,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [lnds_pkg::LEN_W-1:0]          end_length,
  output logic [lnds_pkg::LEN_W-1:0]          best_length,
  output logic [lnds_pkg::IDX_W-1:0]          best_index,
  output logic                                overflow
);

  // Command and status groups between the controller and the datapath.
  lnds_pkg::cmd_t    cmd;
  lnds_pkg::status_t status;

  // The controller walks each transaction through setup, search, update and
  // hand-off; it only accepts input while it is idle.
  lnds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the tail memory, the search bounds, the per-sequence
  // counters and the output register that decouples the consumer.
  lnds_datapath #(
    .MAX_LEN    (MAX_LEN),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .value       (value),
    .start_req   (start_req),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .end_length  (end_length),
    .best_length (best_length),
    .best_index  (best_index),
    .overflow    (overflow)
  );

endmodule
